>>> hw/rtl/tsc_pkg.sv
`timescale 1ns / 1ps

package tsc_pkg;

	// Field widths
	localparam int TICK_W  = 64;
	localparam int SEC_W   = 64;
	localparam int NSEC_W  = 30;
	localparam int RATE_W  = 34;
	localparam int REQ_W   = 2;
	localparam int STAT_W  = 2;
	localparam int CIDX_W  = 2;

	// Stream payload widths, padded to whole bytes
	localparam int S_DATA_W = 160;
	localparam int M_DATA_W = 96;

	// Divider step counts: full 64-bit quotient, then a 30-bit fraction
	localparam int SEC_STEPS  = 64;
	localparam int NSEC_STEPS = 30;

	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic [NSEC_W-1:0] NSEC_ONE_SEC = 30'd1000000000;

	typedef enum logic [REQ_W-1:0] {
		REQ_RES  = 2'd0,
		REQ_READ = 2'd1,
		REQ_SET  = 2'd2,
		REQ_INIT = 2'd3
	} req_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_PERM  = 2'd1,
		ST_INVAL = 2'd2
	} status_t;

	typedef enum logic [CIDX_W-1:0] {
		CFG_TICK_RATE   = 2'd0,
		CFG_CLOCK_MODE  = 2'd1,
		CFG_SET_ALLOWED = 2'd2
	} cfg_idx_t;

	// Work classes handed from the front to the back
	typedef enum logic [1:0] {
		OP_RES    = 2'd0,
		OP_READ   = 2'd1,
		OP_DIRECT = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_DIV_SEC,
		BK_MUL,
		BK_DIV_NS,
		BK_FIN
	} bk_state_t;

	typedef struct packed {
		op_t               op;
		status_t           status;
		logic [TICK_W-1:0] elapsed;
		logic [SEC_W-1:0]  base_sec;
		logic [NSEC_W-1:0] base_nsec;
	} entry_t;

	typedef struct packed {
		logic [RATE_W-1:0] tick_rate;
		logic              clock_mode;
	} cfg_t;

endpackage

>>> hw/rtl/tsc_front.sv
`timescale 1ns / 1ps

module tsc_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tsc_pkg::CIDX_W-1:0]     cfg_index,
	input  logic [tsc_pkg::RATE_W-1:0]     cfg_data,
	input  logic                           push,
	input  logic [tsc_pkg::REQ_W-1:0]      req_type,
	input  logic [tsc_pkg::TICK_W-1:0]     tick_count,
	input  logic [tsc_pkg::SEC_W-1:0]      set_sec,
	input  logic [tsc_pkg::NSEC_W-1:0]     set_nsec,
	output tsc_pkg::entry_t                entry,
	output tsc_pkg::cfg_t                  cfg
);

	logic [tsc_pkg::RATE_W-1:0] tick_rate_q;
	logic                       clock_mode_q;
	logic                       set_allowed_q;
	logic [tsc_pkg::TICK_W-1:0] base_ticks_q;
	logic [tsc_pkg::SEC_W-1:0]  base_sec_q;
	logic [tsc_pkg::NSEC_W-1:0] base_nsec_q;

	logic rate_zero;
	logic set_refused;
	logic set_bad_nsec;

	assign rate_zero    = (tick_rate_q == '0);
	assign set_refused  = clock_mode_q || !set_allowed_q;
	assign set_bad_nsec = (set_nsec >= tsc_pkg::NSEC_ONE_SEC);

	assign cfg.tick_rate  = tick_rate_q;
	assign cfg.clock_mode = clock_mode_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_rate_q   <= '0;
			clock_mode_q  <= 1'b0;
			set_allowed_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (tsc_pkg::cfg_idx_t'(cfg_index))
				tsc_pkg::CFG_TICK_RATE:   tick_rate_q   <= cfg_data;
				tsc_pkg::CFG_CLOCK_MODE:  clock_mode_q  <= cfg_data[0];
				tsc_pkg::CFG_SET_ALLOWED: set_allowed_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Classify the request; reads take the elapsed count and base time now
	always_comb begin
		entry.op        = tsc_pkg::OP_DIRECT;
		entry.status    = tsc_pkg::ST_OK;
		entry.elapsed   = tick_count - base_ticks_q;
		entry.base_sec  = base_sec_q;
		entry.base_nsec = base_nsec_q;
		unique case (tsc_pkg::req_t'(req_type))
			tsc_pkg::REQ_RES: begin
				if (rate_zero) entry.status = tsc_pkg::ST_INVAL;
				else           entry.op     = tsc_pkg::OP_RES;
			end
			tsc_pkg::REQ_READ: begin
				if (rate_zero) entry.status = tsc_pkg::ST_INVAL;
				else           entry.op     = tsc_pkg::OP_READ;
			end
			tsc_pkg::REQ_SET: begin
				if (set_refused)       entry.status = tsc_pkg::ST_PERM;
				else if (set_bad_nsec) entry.status = tsc_pkg::ST_INVAL;
			end
			tsc_pkg::REQ_INIT: ;
			default: ;
		endcase
	end

	// Base time and base count, updated by set and init at the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_ticks_q <= '0;
			base_sec_q   <= '0;
			base_nsec_q  <= '0;
		end else if (push) begin
			if (req_type == tsc_pkg::REQ_SET && !set_refused && !set_bad_nsec) begin
				base_ticks_q <= tick_count;
				base_sec_q   <= set_sec;
				base_nsec_q  <= set_nsec;
			end else if (req_type == tsc_pkg::REQ_INIT) begin
				base_ticks_q <= tick_count;
				base_sec_q   <= '0;
				base_nsec_q  <= '0;
			end
		end
	end

endmodule

>>> hw/rtl/tsc_queue.sv
`timescale 1ns / 1ps

module tsc_queue #(
	parameter int DEPTH = tsc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  tsc_pkg::entry_t push_entry,
	output logic            full,
	input  logic            pop,
	output logic            valid,
	output tsc_pkg::entry_t head
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	tsc_pkg::entry_t  mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign valid = (cnt_q != '0);
	assign head  = mem_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_entry;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

>>> hw/rtl/tsc_back.sv
`timescale 1ns / 1ps

module tsc_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tsc_pkg::cfg_t                 cfg,
	input  logic                          q_valid,
	input  tsc_pkg::entry_t               q_head,
	output logic                          q_pop,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [tsc_pkg::M_DATA_W-1:0]  m_tdata,
	output logic [tsc_pkg::STAT_W-1:0]    m_tuser
);

	localparam int CNT_W = $clog2(tsc_pkg::SEC_STEPS);
	localparam int SEC_W  = tsc_pkg::SEC_W;
	localparam int NSEC_W = tsc_pkg::NSEC_W;
	localparam int RATE_W = tsc_pkg::RATE_W;

	tsc_pkg::bk_state_t state_q, state_d;

	logic [CNT_W-1:0]  cnt_q;
	logic [RATE_W-1:0] rem_q;
	logic [63:0]       dq_q;
	logic [SEC_W-1:0]  esec_q;
	tsc_pkg::entry_t   ent_q;

	logic                      out_valid_q;
	logic [tsc_pkg::STAT_W-1:0] out_status_q;
	logic [SEC_W-1:0]          out_sec_q;
	logic [NSEC_W-1:0]         out_nsec_q;

	logic [RATE_W:0]   trial;
	logic [RATE_W:0]   diff;
	logic              ge;
	logic [63:0]       prod;
	logic              step_en;
	logic              out_free;
	logic              fin_load;
	logic              last_sec;
	logic              last_ns;

	logic [NSEC_W:0]   nsec_sum;
	logic              nsec_carry;
	logic [tsc_pkg::STAT_W-1:0] res_status;
	logic [SEC_W-1:0]  res_sec;
	logic [NSEC_W-1:0] res_nsec;

	// One restoring division step: shift in the next dividend bit
	assign trial = {rem_q, dq_q[63]};
	assign diff  = trial - {1'b0, cfg.tick_rate};
	assign ge    = (trial >= {1'b0, cfg.tick_rate});

	// Remainder scaled to nanoseconds; it stays below rate * 2^30
	assign prod = {{(64 - RATE_W){1'b0}}, rem_q} *
		{{(64 - NSEC_W){1'b0}}, tsc_pkg::NSEC_ONE_SEC};

	assign out_free = !out_valid_q || m_tready;
	assign last_sec = (cnt_q == CNT_W'(tsc_pkg::SEC_STEPS - 1));
	assign last_ns  = (cnt_q == CNT_W'(tsc_pkg::NSEC_STEPS - 1));

	// Next state
	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		step_en  = 1'b0;
		fin_load = 1'b0;
		unique case (state_q)
			tsc_pkg::BK_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					unique case (q_head.op)
						tsc_pkg::OP_READ: state_d = tsc_pkg::BK_DIV_SEC;
						tsc_pkg::OP_RES:  state_d = tsc_pkg::BK_DIV_NS;
						default:          state_d = tsc_pkg::BK_FIN;
					endcase
				end
			end
			tsc_pkg::BK_DIV_SEC: begin
				step_en = 1'b1;
				if (last_sec) state_d = tsc_pkg::BK_MUL;
			end
			tsc_pkg::BK_MUL: state_d = tsc_pkg::BK_DIV_NS;
			tsc_pkg::BK_DIV_NS: begin
				step_en = 1'b1;
				if (last_ns) state_d = tsc_pkg::BK_FIN;
			end
			tsc_pkg::BK_FIN: begin
				if (out_free) begin
					fin_load = 1'b1;
					state_d  = tsc_pkg::BK_IDLE;
				end
			end
			default: state_d = tsc_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= tsc_pkg::BK_IDLE;
		else         state_q <= state_d;
	end

	// Divider datapath
	always_ff @(posedge clk) begin
		if (q_pop) begin
			ent_q <= q_head;
			cnt_q <= '0;
			rem_q <= '0;
			if (q_head.op == tsc_pkg::OP_RES) begin
				dq_q <= {tsc_pkg::NSEC_ONE_SEC, (64 - NSEC_W)'(0)};
			end else begin
				dq_q <= q_head.elapsed;
			end
		end else if (step_en) begin
			cnt_q <= cnt_q + 1'b1;
			rem_q <= ge ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
			dq_q  <= {dq_q[62:0], ge};
		end else if (state_q == tsc_pkg::BK_MUL) begin
			// Seconds done; load the scaled remainder as the next dividend
			esec_q <= dq_q;
			cnt_q  <= '0;
			rem_q  <= prod[63:NSEC_W];
			dq_q   <= {prod[NSEC_W-1:0], (64 - NSEC_W)'(0)};
		end
	end

	// Final result: base time added, with a nanosecond carry into seconds, in realtime mode
	assign nsec_sum   = {1'b0, ent_q.base_nsec} + {1'b0, dq_q[NSEC_W-1:0]};
	assign nsec_carry = (nsec_sum >= {1'b0, tsc_pkg::NSEC_ONE_SEC});

	always_comb begin
		res_status = tsc_pkg::ST_OK;
		res_sec    = '0;
		res_nsec   = '0;
		unique case (ent_q.op)
			tsc_pkg::OP_RES: res_nsec = dq_q[NSEC_W-1:0];
			tsc_pkg::OP_READ: begin
				if (cfg.clock_mode) begin
					res_sec  = esec_q;
					res_nsec = dq_q[NSEC_W-1:0];
				end else begin
					res_sec  = ent_q.base_sec + esec_q + SEC_W'(nsec_carry);
					res_nsec = nsec_carry ?
						NSEC_W'(nsec_sum - {1'b0, tsc_pkg::NSEC_ONE_SEC}) :
						nsec_sum[NSEC_W-1:0];
				end
			end
			default: res_status = ent_q.status;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			out_status_q <= res_status;
			out_sec_q    <= res_sec;
			out_nsec_q   <= res_nsec;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {(tsc_pkg::M_DATA_W - SEC_W - NSEC_W)'(0), out_nsec_q, out_sec_q};

endmodule

>>> hw/rtl/tick_to_timespec_clock.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake          Payload
// s_*       in         s_tvalid/s_tready  tuser: req_type; tdata: tick_count, set_sec, set_nsec
// m_*       out        m_tvalid/m_tready  tuser: status; tdata: time_sec, time_nsec
// cfg_*     in         cfg_we             cfg_index, cfg_data (no read-back)
//
// A read runs a 64-step quotient loop for seconds, one multiply,
// then a 30-step loop for nanoseconds, all on one shared restoring divider.
// A resolution runs only the 30-step loop; set, init and refused requests go straight to the result.
// The front queue holds QUEUE_DEPTH requests; s_tready drops only when it is full.
// The output register waits for m_tready while the back already starts the next item.
// Reset clears configuration to its defaults and the base time and count to zero.

module tick_to_timespec_clock #(
	parameter int QUEUE_DEPTH = tsc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [tsc_pkg::CIDX_W-1:0]    cfg_index,
	input  logic [tsc_pkg::RATE_W-1:0]    cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// tick_count [63:0], set_sec [127:64], set_nsec [157:128], zero pad
	input  logic [tsc_pkg::S_DATA_W-1:0]  s_tdata,
	// req_type [1:0]
	input  logic [tsc_pkg::REQ_W-1:0]     s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// time_sec [63:0], time_nsec [93:64], zero pad
	output logic [tsc_pkg::M_DATA_W-1:0]  m_tdata,
	// status [1:0]
	output logic [tsc_pkg::STAT_W-1:0]    m_tuser
);

	tsc_pkg::entry_t push_entry;
	tsc_pkg::entry_t q_head;
	tsc_pkg::cfg_t   cfg;
	logic            push;
	logic            q_full;
	logic            q_valid;
	logic            q_pop;

	assign s_tready = !q_full;
	assign push     = s_tvalid && s_tready;

	tsc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.push       (push),
		.req_type   (s_tuser),
		.tick_count (s_tdata[63:0]),
		.set_sec    (s_tdata[127:64]),
		.set_nsec   (s_tdata[157:128]),
		.entry      (push_entry),
		.cfg        (cfg)
	);

	tsc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (q_pop),
		.valid      (q_valid),
		.head       (q_head)
	);

	tsc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.q_valid  (q_valid),
		.q_head   (q_head),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

>>> tb/tick_to_timespec_clock_tb.sv
`timescale 1ns / 1ps

module tick_to_timespec_clock_tb;

	localparam logic [63:0] NS_PER_SEC   = 64'd1_000_000_000;
	localparam logic [29:0] NSEC_LAST    = 30'd999_999_999;
	localparam logic [29:0] NSEC_TOP     = 30'h3FFF_FFFF;
	localparam logic [33:0] RATE_MAX     = 34'h3_FFFF_FFFF;
	localparam logic [63:0] SEC_MAX      = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] SEC_MIN      = 64'h8000_0000_0000_0000;
	localparam logic [63:0] TICKS_MAX    = '1;
	localparam int          DRAIN_CYCLES = 120;

	typedef struct packed {
		tsc_pkg::status_t status;
		logic [63:0]      sec;
		logic [29:0]      nsec;
	} time_result_t;

	logic                         clk       = 1'b0;
	logic                         arst_n    = 1'b0;
	logic                         cfg_we    = 1'b0;
	logic [tsc_pkg::CIDX_W-1:0]   cfg_index = '0;
	logic [tsc_pkg::RATE_W-1:0]   cfg_data  = '0;
	logic                         s_tvalid  = 1'b0;
	logic                         s_tready;
	// tick_count [63:0], set_sec [127:64], set_nsec [157:128], zero pad
	logic [tsc_pkg::S_DATA_W-1:0] s_tdata   = '0;
	// req_type [1:0]
	logic [tsc_pkg::REQ_W-1:0]    s_tuser   = '0;
	logic                         m_tvalid;
	logic                         m_tready  = 1'b0;
	// time_sec [63:0], time_nsec [93:64], zero pad
	logic [tsc_pkg::M_DATA_W-1:0] m_tdata;
	// status [1:0]
	logic [tsc_pkg::STAT_W-1:0]   m_tuser;

	// Predicted clock state and configuration
	logic [33:0] rate_cfg     = '0;
	logic        mono_cfg     = 1'b0;
	logic        set_ok_cfg   = 1'b1;
	logic [63:0] anchor_ticks = '0;
	logic [63:0] anchor_sec   = '0;
	logic [29:0] anchor_nsec  = '0;

	time_result_t expected_times[$];
	time_result_t front_time;

	int unsigned send_idle_pct   = 0;
	int unsigned recv_idle_pct   = 0;
	int unsigned rx_hold_request = 0;
	int unsigned rx_hold_left    = 0;
	int unsigned mismatches      = 0;
	int unsigned results_checked = 0;
	int unsigned requests_sent   = 0;
	int unsigned config_count    = 0;
	int unsigned kind_count[4]   = '{0, 0, 0, 0};

	tick_to_timespec_clock DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Expected time for one request; updates the base time on set and init
	function automatic time_result_t predict_timespec(tsc_pkg::req_t req,
			logic [63:0] ticks, logic [63:0] sec, logic [29:0] nsec);
		time_result_t r;
		logic [63:0]  rate64;
		logic [63:0]  elapsed;
		logic [63:0]  whole;
		logic [63:0]  frac;
		logic [63:0]  nsum;
		r.status = tsc_pkg::ST_OK;
		r.sec    = '0;
		r.nsec   = '0;
		rate64   = {30'b0, rate_cfg};
		case (req)
			tsc_pkg::REQ_RES: begin
				if (rate_cfg == '0)
					r.status = tsc_pkg::ST_INVAL;
				else
					r.nsec = 30'(NS_PER_SEC / rate64);
			end
			tsc_pkg::REQ_READ: begin
				if (rate_cfg == '0) begin
					r.status = tsc_pkg::ST_INVAL;
				end else begin
					elapsed = ticks - anchor_ticks;
					whole   = elapsed / rate64;
					// remainder < 2^34 and 10^9 < 2^30, no overflow
					frac    = ((elapsed % rate64) * NS_PER_SEC) / rate64;
					if (mono_cfg) begin
						r.sec  = whole;
						r.nsec = frac[29:0];
					end else begin
						r.sec = anchor_sec + whole;
						nsum  = {34'b0, anchor_nsec} + frac;
						if (nsum >= NS_PER_SEC) begin
							r.sec = r.sec + 64'd1;
							nsum  = nsum - NS_PER_SEC;
						end
						r.nsec = nsum[29:0];
					end
				end
			end
			tsc_pkg::REQ_SET: begin
				if (mono_cfg || !set_ok_cfg) begin
					r.status = tsc_pkg::ST_PERM;
				end else if ({34'b0, nsec} >= NS_PER_SEC) begin
					r.status = tsc_pkg::ST_INVAL;
				end else begin
					anchor_sec   = sec;
					anchor_nsec  = nsec;
					anchor_ticks = ticks;
				end
			end
			default: begin
				anchor_ticks = ticks;
				anchor_sec   = '0;
				anchor_nsec  = '0;
			end
		endcase
		return r;
	endfunction

	// One request transfer, with random idle cycles ahead of it
	task automatic send_request(tsc_pkg::req_t req, logic [63:0] ticks, logic [63:0] sec,
			logic [29:0] nsec);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= {2'b00, nsec, sec, ticks};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		expected_times.push_back(predict_timespec(req, ticks, sec, nsec));
		requests_sent++;
		kind_count[req]++;
	endtask

	// Stop sending and let every outstanding result come back
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (expected_times.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write all three registers once the block has gone quiet
	task automatic configure(logic [33:0] rate, logic mono, logic allow);
		logic [33:0] junk;
		wait_idle();
		junk      = 34'({$urandom, $urandom});
		cfg_we    <= 1'b1;
		cfg_index <= tsc_pkg::CFG_TICK_RATE;
		cfg_data  <= rate;
		@(posedge clk);
		cfg_index <= tsc_pkg::CFG_CLOCK_MODE;
		cfg_data  <= {junk[33:1], mono};
		@(posedge clk);
		cfg_index <= tsc_pkg::CFG_SET_ALLOWED;
		cfg_data  <= {junk[32:0], allow};
		@(posedge clk);
		cfg_we     <= 1'b0;
		rate_cfg   = rate;
		mono_cfg   = mono;
		set_ok_cfg = allow;
		config_count++;
	endtask

	// Clock not yet given a rate, straight after reset
	task automatic test_uninitialized();
		send_request(tsc_pkg::REQ_RES, 64'd0, '0, '0);
		send_request(tsc_pkg::REQ_READ, TICKS_MAX, '0, '0);
		send_request(tsc_pkg::REQ_SET, 64'd5, '1, NSEC_LAST);
		send_request(tsc_pkg::REQ_INIT, 64'd0, SEC_MIN, NSEC_TOP);
	endtask

	// Field extremes, carries, wraps, refusals and resolution edges
	task automatic test_corner_cases();
		configure(RATE_MAX, 1'b0, 1'b1);
		send_request(tsc_pkg::REQ_RES, 64'd0, '0, '0);
		send_request(tsc_pkg::REQ_SET, 64'd0, SEC_MAX, NSEC_LAST);
		send_request(tsc_pkg::REQ_READ, TICKS_MAX, '0, '0);
		send_request(tsc_pkg::REQ_SET, 64'd9, 64'd3, NSEC_TOP);
		send_request(tsc_pkg::REQ_SET, TICKS_MAX, SEC_MIN, 30'd0);
		send_request(tsc_pkg::REQ_READ, 64'd0, '0, '0);

		// monotonic: set refused, elapsed wraps past the base count
		configure(34'd1, 1'b1, 1'b1);
		send_request(tsc_pkg::REQ_SET, 64'd0, 64'd1, 30'd1);
		send_request(tsc_pkg::REQ_READ, 64'd0, '0, '0);
		send_request(tsc_pkg::REQ_RES, 64'd0, '0, '0);
		send_request(tsc_pkg::REQ_INIT, TICKS_MAX, '0, '0);
		send_request(tsc_pkg::REQ_READ, SEC_MAX, '0, '0);

		configure(34'd1_000_000_000, 1'b0, 1'b0);
		send_request(tsc_pkg::REQ_SET, 64'd0, 64'd7, 30'd7);
		send_request(tsc_pkg::REQ_RES, 64'd0, '0, '0);
		send_request(tsc_pkg::REQ_READ, 64'd123_456_789_012, '0, '0);

		// nanosecond carry into seconds
		configure(34'd1_000_000_001, 1'b0, 1'b1);
		send_request(tsc_pkg::REQ_RES, 64'd0, '0, '0);
		send_request(tsc_pkg::REQ_SET, 64'd0, 64'd5, NSEC_LAST);
		send_request(tsc_pkg::REQ_READ, 64'd1_999_999_999, '0, '0);
		send_request(tsc_pkg::REQ_SET, 64'd0, 64'd5, 30'd1_000_000_000);
	endtask

	// Random requests over a series of random register settings
	task automatic test_random_traffic(int unsigned blocks, int unsigned per_block);
		logic [33:0]   rate;
		logic [63:0]   tick_now;
		logic [63:0]   sec;
		logic [29:0]   nsec;
		int unsigned   pick;
		tsc_pkg::req_t req;
		tick_now = {$urandom, $urandom};
		for (int unsigned b = 0; b < blocks; b++) begin
			case ($urandom_range(7))
				0:       rate = '0;
				1:       rate = 34'd1;
				2:       rate = 34'($urandom_range(2, 5000));
				3:       rate = 34'd1_000_000_000;
				4:       rate = 34'd1_000_000_000 + 34'($urandom_range(1, 3));
				5:       rate = RATE_MAX;
				default: rate = 34'({$urandom, $urandom});
			endcase
			configure(rate, 1'($urandom_range(1)), $urandom_range(3) != 0);
			for (int unsigned i = 0; i < per_block; i++) begin
				// counter mostly moves forward, sometimes jumps or steps back
				case ($urandom_range(9))
					0:       tick_now = {$urandom, $urandom};
					1:       tick_now = tick_now - 64'($urandom_range(0, 1000));
					2, 3, 4: tick_now = tick_now + 64'($urandom_range(0, 1000));
					default: tick_now = tick_now + {$urandom_range(0, 15), $urandom};
				endcase
				pick = $urandom_range(99);
				req  = (pick < 45) ? tsc_pkg::REQ_READ : (pick < 65) ? tsc_pkg::REQ_SET :
					(pick < 75) ? tsc_pkg::REQ_INIT : tsc_pkg::REQ_RES;
				case ($urandom_range(7))
					0:       sec = SEC_MAX - 64'($urandom_range(0, 3));
					1:       sec = SEC_MIN + 64'($urandom_range(0, 3));
					2:       sec = 64'($urandom_range(0, 100));
					default: sec = {$urandom, $urandom};
				endcase
				if ($urandom_range(9) == 0)
					nsec = 30'($urandom_range(1_000_000_000, 1_073_741_823));
				else
					nsec = 30'($urandom_range(0, 999_999_999));
				send_request(req, tick_now, sec, nsec);
			end
		end
	endtask

	// Receiver holds off long enough for the block to fill and stall its input
	task automatic test_backpressure();
		configure(34'd1000, 1'b0, 1'b1);
		rx_hold_request = 600;
		for (int i = 0; i < 12; i++)
			send_request((i % 3 == 0) ? tsc_pkg::REQ_SET : tsc_pkg::REQ_READ,
				64'(i) * 64'd777_777,
				{$urandom, $urandom}, 30'($urandom_range(0, 999_999_999)));
	endtask

	// Result receiver: random stalls plus an occasional long hold-off
	always @(posedge clk) begin
		if (rx_hold_request != 0) begin
			rx_hold_left    = rx_hold_request;
			rx_hold_request = 0;
		end
		if (rx_hold_left != 0) begin
			m_tready <= 1'b0;
			rx_hold_left--;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Compare each result transfer against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_times.size() == 0) begin
				$error("result transfer with nothing expected: status %0d", m_tuser);
				mismatches++;
			end else begin
				front_time = expected_times.pop_front();
				if (m_tuser !== front_time.status) begin
					$error("status mismatch: expected %0d, actual %0d",
						front_time.status, m_tuser);
					mismatches++;
				end
				if (m_tdata[63:0] !== front_time.sec) begin
					$error("time_sec mismatch: expected %0d, actual %0d",
						$signed(front_time.sec), $signed(m_tdata[63:0]));
					mismatches++;
				end
				if (m_tdata[93:64] !== front_time.nsec) begin
					$error("time_nsec mismatch: expected %0d, actual %0d",
						front_time.nsec, m_tdata[93:64]);
					mismatches++;
				end
			end
			results_checked++;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 27;
		recv_idle_pct = 46;
		test_uninitialized();
		test_corner_cases();
		test_random_traffic(5, 100);

		send_idle_pct = 46;
		recv_idle_pct = 27;
		test_random_traffic(5, 100);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(5, 100);
		test_backpressure();

		wait_idle();
		$display("tb: %0d requests (%0d resolution, %0d read, %0d set, %0d init), %0d results",
			requests_sent, kind_count[tsc_pkg::REQ_RES], kind_count[tsc_pkg::REQ_READ],
			kind_count[tsc_pkg::REQ_SET], kind_count[tsc_pkg::REQ_INIT], results_checked);
		$display("tb: %0d register settings, %0d mismatches", config_count, mismatches);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Watchdog
	initial begin
		#10_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/tsc_pkg.sv
hw/rtl/tsc_front.sv
hw/rtl/tsc_queue.sv
hw/rtl/tsc_back.sv
hw/rtl/tick_to_timespec_clock.sv
tb/tick_to_timespec_clock_tb.sv
